// File: design/averaged_hysteresis_thermostat_defines.svh
// Assertion macros for the averaged hysteresis thermostat checker.
`ifndef AVERAGED_HYSTERESIS_THERMOSTAT_DEFINES_SVH
`define AVERAGED_HYSTERESIS_THERMOSTAT_DEFINES_SVH

// Checked on the rising clock edge, muted while reset is asserted.
// The user scope must provide clk_i and rst_ni.
`define AHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define AHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: design/aht_pkg.sv
// Shared constants, types and register codes of the averaged hysteresis thermostat.
package aht_pkg;

  localparam int RING_DEPTH_LOG2 = 4;
  localparam int RING_DEPTH      = 1 << RING_DEPTH_LOG2;
  localparam int SAMPLE_W        = 8;
  localparam int SUM_W           = SAMPLE_W + RING_DEPTH_LOG2;
  localparam int SETPOINT_W      = 6;
  localparam int HYST_W          = 4;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 8;

  localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = '0;
  localparam logic [HYST_W-1:0]     HYST_RESET     = HYST_W'(2);

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT   = CFG_IDX_W'(0),
    CFG_HYSTERESIS = CFG_IDX_W'(1)
  } cfg_reg_e;

  typedef logic [RING_DEPTH_LOG2-1:0] slot_t;
  typedef logic [SAMPLE_W-1:0]        sample_t;

  typedef struct packed {
    logic [SETPOINT_W-1:0] setpoint;
    logic [HYST_W-1:0]     hysteresis;
  } cfg_t;

  // ring access from the datapath
  typedef struct packed {
    logic    rd_en;
    slot_t   rd_slot;
    logic    wr_en;
    slot_t   wr_slot;
    sample_t wr_data;
    logic    fill;
    sample_t fill_data;
  } ring_req_t;

endpackage

// File: design/aht_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
interface aht_in_if import aht_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    override;
  logic    preload;

  modport source (output valid, output sample, output override, output preload,
                  input ready);
  modport sink   (input valid, input sample, input override, input preload,
                  output ready);
endinterface

interface aht_out_if import aht_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t average;
  logic    relay_on;

  modport source (output valid, output average, output relay_on, input ready);
  modport sink   (input valid, input average, input relay_on, output ready);
endinterface

interface aht_cfg_if import aht_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/averaged_hysteresis_thermostat.sv
// Averaged hysteresis thermostat: top level.
//
// in_if carries one temperature word per transfer (sample, override, preload).
// out_if returns one word per input word: the floor mean of the 16-entry
// sample ring after that word and the relay state. cfg_if writes setpoint
// (index 0) and hysteresis (index 1); it is always ready, and writes are
// meant to happen while no word is in flight.
// An accepted word passes the compute stage and then the output register
// before its result is offered on out_if.
// Throughput: one word per cycle while out_if does not stall. The ring entry
// being replaced is read from the RAM in the accept cycle and written back as
// the word leaves the compute stage, when the running sum also updates.
// A preload word marks all ring entries invalid at once and remembers its
// sample as their value, so no clearing pass is needed.
// Reset (rst_ni low, asynchronous) empties the pipeline, zeros the ring,
// write slot and running sum, turns the relay off and loads the register
// defaults; the block is ready to take words as soon as reset is released.
// When out_if stalls, the finished word is held and one more input word is
// taken into the compute stage; then in_if.ready drops until out_if drains.
module averaged_hysteresis_thermostat import aht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  aht_in_if.sink    in_if,
  aht_out_if.source out_if,
  aht_cfg_if.sink   cfg_if
);

  cfg_t      cfg;
  ring_req_t ring_req;
  sample_t   ring_old;

  logic    in_acc;
  logic    s1_fire;

  logic    s1_valid_q;
  sample_t s1_sample_q;
  logic    s1_override_q;
  logic    s1_preload_q;
  slot_t   s1_slot_q;

  slot_t              slot_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W-1:0]   sum_d;
  logic               relay_q;
  logic               relay_d;
  sample_t            avg;
  logic [SETPOINT_W-1:0] hyst_ext;

  logic    out_valid_q;
  sample_t out_average_q;
  logic    out_relay_q;

  aht_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  aht_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .old_o  (ring_old)
  );

  // handshakes
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_fire;
  assign in_acc      = in_if.valid && in_if.ready;

  // ring access: read the slot at accept, write it back when the word completes
  always_comb begin
    ring_req.rd_en     = in_acc;
    ring_req.rd_slot   = slot_q;
    ring_req.wr_en     = s1_fire && !s1_preload_q;
    ring_req.wr_slot   = s1_slot_q;
    ring_req.wr_data   = s1_sample_q;
    ring_req.fill      = s1_fire && s1_preload_q;
    ring_req.fill_data = s1_sample_q;
  end

  // running sum, mean and relay decision
  always_comb begin
    hyst_ext = SETPOINT_W'(cfg.hysteresis);
    if (s1_preload_q) begin
      sum_d = {s1_sample_q, {RING_DEPTH_LOG2{1'b0}}};
    end else begin
      sum_d = sum_q - SUM_W'(ring_old) + SUM_W'(s1_sample_q);
    end
    avg     = sum_d[SUM_W-1:RING_DEPTH_LOG2];
    relay_d = relay_q;
    if (!s1_preload_q) begin
      if (avg > SAMPLE_W'(cfg.setpoint) || s1_override_q) begin
        relay_d = 1'b1;
      end else if (cfg.setpoint >= hyst_ext &&
                   avg <= SAMPLE_W'(cfg.setpoint - hyst_ext)) begin
        // a negative threshold never turns the relay off
        relay_d = 1'b0;
      end
    end
  end

  // write slot advances on every normal word at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (in_acc && !in_if.preload) begin
      slot_q <= slot_q + 1'b1;
    end
  end

  // compute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q   <= in_if.sample;
      s1_override_q <= in_if.override;
      s1_preload_q  <= in_if.preload;
      s1_slot_q     <= slot_q;
    end
  end

  // sum and relay state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      relay_q <= 1'b0;
    end else if (s1_fire) begin
      sum_q   <= sum_d;
      relay_q <= relay_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_average_q <= avg;
      out_relay_q   <= relay_d;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.average  = out_average_q;
  assign out_if.relay_on = out_relay_q;

endmodule

// File: design/aht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/aht_ring.sv
// Sample ring: RAM plus per-entry valid bits and a fill value for preload.
module aht_ring import aht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ring_req_t req_i,
  output sample_t   old_o
);

  logic [RING_DEPTH-1:0] valid_q;
  sample_t               fill_q;
  slot_t                 rd_slot_q;
  sample_t               rdata;

  aht_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_slot),
    .wdata_i (req_i.wr_data),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_slot),
    .rdata_o (rdata)
  );

  // a fill invalidates every entry at once; invalid entries read as the fill value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      fill_q    <= '0;
      rd_slot_q <= '0;
    end else begin
      if (req_i.fill) begin
        valid_q <= '0;
        fill_q  <= req_i.fill_data;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_slot] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_slot_q <= req_i.rd_slot;
      end
    end
  end

  // valid bit is looked up when the data is used, so fills in between count
  assign old_o = valid_q[rd_slot_q] ? rdata : fill_q;

endmodule

// File: design/aht_cfg.sv
// Setpoint and hysteresis registers behind the config write channel.
module aht_cfg import aht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  aht_cfg_if.sink   cfg_if,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_if.ready = 1'b1;

  // decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_SETPOINT:   cfg_d.setpoint   = cfg_if.data[SETPOINT_W-1:0];
        CFG_HYSTERESIS: cfg_d.hysteresis = cfg_if.data[HYST_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint   <= SETPOINT_RESET;
      cfg_q.hysteresis <= HYST_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/aht_checker.sv
// Port-level checker for the averaged hysteresis thermostat, bound to the top level.
`include "averaged_hysteresis_thermostat_defines.svh"

module aht_checker import aht_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input sample_t in_sample_i,
  input logic    in_override_i,
  input logic    in_preload_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input sample_t out_average_i,
  input logic    out_relay_on_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // no word comes out of reset
  `AHT_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_i,
    "result word valid during reset")

  // a stalled result word stays offered
  `AHT_ASSERT(a_out_held, out_valid_i && !out_ready_i |=> out_valid_i,
    "result word dropped while stalled")

  // a preload word reports its own sample as the mean
  `AHT_ASSERT(a_preload_avg,
    (in_acc && in_preload_i) ##1 out_ready_i |=>
      out_valid_i && out_average_i == $past(in_sample_i, 2),
    "preload mean differs from the sample")

  // override forces the relay on for a normal word
  `AHT_ASSERT(a_override_on,
    (in_acc && !in_preload_i && in_override_i) ##1 out_ready_i |=>
      out_valid_i && out_relay_on_i,
    "override word did not turn the relay on")

endmodule

bind averaged_hysteresis_thermostat aht_checker u_aht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_if.valid),
  .in_ready_i     (in_if.ready),
  .in_sample_i    (in_if.sample),
  .in_override_i  (in_if.override),
  .in_preload_i   (in_if.preload),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .out_average_i  (out_if.average),
  .out_relay_on_i (out_if.relay_on)
);

// File: tb/tb_averaged_hysteresis_thermostat.sv
// Self-checking testbench for the averaged hysteresis thermostat.
`timescale 1ns / 1ps

module tb_averaged_hysteresis_thermostat;
  import aht_pkg::*;

  // one temperature word and one reading as they cross the channels
  typedef struct {
    sample_t sample;
    logic    override;
    logic    preload;
  } temp_word_t;

  typedef struct {
    sample_t average;
    logic    relay_on;
  } reading_t;

  logic clk;
  logic rst_n;

  aht_in_if  in_ch ();
  aht_out_if out_ch ();
  aht_cfg_if cfg_ch ();

  averaged_hysteresis_thermostat dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // thermostat state as predicted from the accepted words
  sample_t               hist_ring [RING_DEPTH];
  slot_t                 hist_slot;
  logic [SUM_W-1:0]      hist_sum;
  logic                  relay_held;
  logic [SETPOINT_W-1:0] setpoint_reg;
  logic [HYST_W-1:0]     hyst_reg;

  temp_word_t words_to_send [$];
  reading_t   readings_due [$];
  temp_word_t word_on_bus;
  logic       no_idle;

  int words_taken;
  int readings_checked;
  int preload_count;
  int override_count;
  int relay_turn_on;
  int relay_turn_off;
  int settings_used;
  int mismatches;
  int errors;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // predict the reading for one accepted word and advance the state
  function automatic reading_t next_reading(temp_word_t w);
    reading_t r;
    logic     relay_was;
    int       off_level;
    relay_was = relay_held;
    if (w.preload) begin
      foreach (hist_ring[i]) hist_ring[i] = w.sample;
      hist_sum = SUM_W'(w.sample) << RING_DEPTH_LOG2;
      preload_count++;
    end else begin
      hist_sum = hist_sum - SUM_W'(hist_ring[hist_slot]) + SUM_W'(w.sample);
      hist_ring[hist_slot] = w.sample;
      hist_slot = hist_slot + 1'b1;
    end
    r.average = sample_t'(hist_sum >> RING_DEPTH_LOG2);
    if (!w.preload) begin
      if (w.override) override_count++;
      // signed threshold: a setpoint below hysteresis never turns it off
      off_level = int'(setpoint_reg) - int'(hyst_reg);
      if (int'(r.average) > int'(setpoint_reg) || w.override) begin
        relay_held = 1'b1;
      end else if (int'(r.average) <= off_level) begin
        relay_held = 1'b0;
      end
    end
    if (relay_held && !relay_was) relay_turn_on++;
    if (!relay_held && relay_was) relay_turn_off++;
    r.relay_on = relay_held;
    return r;
  endfunction

  // word driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.sample   <= '0;
      in_ch.override <= 1'b0;
      in_ch.preload  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        readings_due.push_back(next_reading(word_on_bus));
        words_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (words_to_send.size() > 0 && (no_idle || $urandom_range(99) >= 13)) begin
          word_on_bus = words_to_send.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.sample   <= word_on_bus.sample;
          in_ch.override <= word_on_bus.override;
          in_ch.preload  <= word_on_bus.preload;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // reading monitor and checker
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (readings_due.size() == 0) begin
          errors++;
          $display("unexpected reading: avg %0d relay %0b", out_ch.average,
                   out_ch.relay_on);
        end else begin
          reading_t want;
          want = readings_due.pop_front();
          readings_checked++;
          if (out_ch.average !== want.average || out_ch.relay_on !== want.relay_on) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("reading %0d: expected avg %0d relay %0b, got avg %0d relay %0b",
                       readings_checked, want.average, want.relay_on,
                       out_ch.average, out_ch.relay_on);
          end
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 13);
    end
  end

  // register write, block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_SETPOINT) setpoint_reg = value[SETPOINT_W-1:0];
    else if (idx == CFG_HYSTERESIS) hyst_reg = value[HYST_W-1:0];
  endtask

  task automatic push_word(int smp, logic ovr, logic pre);
    temp_word_t w;
    w.sample   = sample_t'(smp);
    w.override = ovr;
    w.preload  = pre;
    words_to_send.push_back(w);
  endtask

  // wait until every queued word is taken and its reading has arrived
  task automatic drain();
    do @(negedge clk);
    while (words_to_send.size() != 0 || in_ch.valid || readings_due.size() != 0);
  endtask

  // mostly samples near the setpoint so the mean hovers in the band
  task automatic queue_random(int count);
    temp_word_t w;
    int         pick;
    int         level;
    repeat (count) begin
      pick       = $urandom_range(99);
      w.preload  = (pick < 6);
      w.override = ($urandom_range(9) == 0);
      if (pick < 78) begin
        level = int'(setpoint_reg) + int'($urandom_range(28)) - 14;
        if (level < 0) level = 0;
        w.sample = sample_t'(level);
      end else begin
        w.sample = sample_t'($urandom_range(255));
      end
      words_to_send.push_back(w);
    end
  endtask

  task automatic set_regs(int sp, int hy);
    write_reg(CFG_SETPOINT, {2'($urandom_range(3)), SETPOINT_W'(sp)});
    write_reg(CFG_HYSTERESIS, {4'($urandom_range(15)), HYST_W'(hy)});
    settings_used++;
  endtask

  // stimulus
  initial begin
    int sp_list [6];
    int hy_list [6];
    rst_n          = 1'b0;
    no_idle        = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    in_ch.override = 1'b0;
    in_ch.preload  = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    foreach (hist_ring[i]) hist_ring[i] = '0;
    hist_slot    = '0;
    hist_sum     = '0;
    relay_held   = 1'b0;
    setpoint_reg = SETPOINT_RESET;
    hyst_reg     = HYST_RESET;
    settings_used = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset registers: threshold below zero, relay never turns off
    push_word(0, 1'b0, 1'b0);
    push_word(255, 1'b0, 1'b0);
    push_word(0, 1'b0, 1'b1);
    push_word(0, 1'b0, 1'b0);
    push_word(128, 1'b1, 1'b1);
    drain();

    // setpoint 40, hysteresis 5 with junk in the upper data bits
    write_reg(CFG_SETPOINT, 8'hE8);
    write_reg(CFG_HYSTERESIS, 8'hF5);
    write_reg(CFG_IDX_W'(CFG_HYSTERESIS) + 1'b1, 8'hFF);
    settings_used++;
    push_word(40, 1'b0, 1'b1);
    push_word(40, 1'b0, 1'b0);
    push_word(35, 1'b0, 1'b1);
    push_word(35, 1'b0, 1'b0);
    push_word(36, 1'b1, 1'b0);
    push_word(35, 1'b0, 1'b0);
    push_word(41, 1'b0, 1'b1);
    push_word(41, 1'b0, 1'b0);
    push_word(255, 1'b0, 1'b1);
    push_word(255, 1'b0, 1'b0);
    push_word(0, 1'b0, 1'b0);
    drain();

    // top setpoint, no hysteresis
    set_regs(63, 0);
    push_word(63, 1'b0, 1'b1);
    push_word(63, 1'b0, 1'b0);
    push_word(255, 1'b0, 1'b0);
    drain();

    // zero setpoint, zero then full hysteresis
    set_regs(0, 0);
    push_word(0, 1'b0, 1'b1);
    push_word(0, 1'b0, 1'b0);
    drain();
    set_regs(0, 15);
    push_word(255, 1'b1, 1'b0);
    push_word(0, 1'b0, 1'b0);
    drain();

    // random phases across several settings
    sp_list = '{63, 3, 20, 63, 0, 0};
    hy_list = '{15, 12, 4, 0, 0, 15};
    sp_list[2] = $urandom_range(63);
    hy_list[2] = $urandom_range(15);
    foreach (sp_list[p]) begin
      set_regs(sp_list[p], hy_list[p]);
      no_idle = (p == 3);
      if (p == 1) begin
        // sender holds until every reading is back, then resumes
        queue_random(45);
        drain();
        queue_random(45);
      end else begin
        queue_random(90);
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (5) @(posedge clk);
    errors += readings_due.size();
    $display("covered %0d words (%0d preloads, %0d overrides) over %0d register settings",
             words_taken, preload_count, override_count, settings_used);
    $display("checked %0d readings; relay turned on %0d and off %0d times",
             readings_checked, relay_turn_on, relay_turn_off);
    if (errors == 0) begin
      $display("averaged_hysteresis_thermostat test passed");
    end else begin
      $display("averaged_hysteresis_thermostat test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("averaged_hysteresis_thermostat test failed");
    $finish;
  end

endmodule
